// ===== src/clr_pkg.sv =====
package clr_pkg;

  localparam int COORD_W = 16;
  // The error term reaches about twice the longest span, so 20 bits leave headroom.
  localparam int ERR_W = 20;

  localparam logic [1:0] ACT_DRAW  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] OP_LINE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] PIX_MSB = 8'h80;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic                      white;
    logic                      in_store;
    logic [15:0]               addr;
    logic [7:0]                value;
  } cmd_t;

endpackage

// ===== src/clipped_line_raster_1bpp.sv =====
// A read passes the address stage, the modify and write stage and the output register before
// out_valid rises; byte writes retire one per cycle while no draw is walking. A draw enters a
// setup state, then walks max(|dx|, |dy|) + 1 pixels, one pixel step per cycle, through the
// walker's read-modify-write on a frame memory with separate read and write ports. A two-entry
// command queue accepts items during a draw until full. Reset clears the control state only;
// the frame memory is not cleared and holds undefined data until each byte is written.
module clipped_line_raster_1bpp #(
  parameter int PIXEL_COLUMNS = 800,
  parameter int PIXEL_ROWS    = 480
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  input  logic signed [15:0] in_end_x,
  input  logic signed [15:0] in_end_y,
  input  logic               in_ink_white,
  input  logic [15:0]        in_byte_address,
  input  logic [7:0]         in_byte_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_read_value
);

  logic          q_full, q_push, q_pop, q_head_valid;
  clr_pkg::cmd_t q_push_cmd, q_head_cmd;

  clr_front #(
    .PIXEL_COLUMNS(PIXEL_COLUMNS),
    .PIXEL_ROWS   (PIXEL_ROWS)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_ink_white   (in_ink_white),
    .in_byte_address(in_byte_address),
    .in_byte_value  (in_byte_value),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_push_cmd)
  );

  clr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_cmd  (q_head_cmd)
  );

  clr_back #(
    .PIXEL_COLUMNS(PIXEL_COLUMNS),
    .PIXEL_ROWS   (PIXEL_ROWS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_head_valid),
    .q_cmd         (q_head_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_value(out_read_value)
  );

endmodule

// ===== src/clr_front.sv =====
module clr_front #(
  parameter int PIXEL_COLUMNS = 800,
  parameter int PIXEL_ROWS    = 480
) (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic signed [15:0]   in_start_x,
  input  logic signed [15:0]   in_start_y,
  input  logic signed [15:0]   in_end_x,
  input  logic signed [15:0]   in_end_y,
  input  logic                 in_ink_white,
  input  logic [15:0]          in_byte_address,
  input  logic [7:0]           in_byte_value,
  input  logic                 q_full,
  output logic                 q_push,
  output clr_pkg::cmd_t        q_cmd
);

  localparam int ROW_BYTES   = (PIXEL_COLUMNS + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * PIXEL_ROWS;
  localparam logic signed [15:0] COL_LAST = 16'(PIXEL_COLUMNS - 1);
  localparam logic signed [15:0] ROW_LAST = 16'(PIXEL_ROWS - 1);

  logic signed [15:0] lo_x, hi_x, lo_y, hi_y;
  logic               keep;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && keep;

  assign lo_x = (in_start_x < in_end_x) ? in_start_x : in_end_x;
  assign hi_x = (in_start_x < in_end_x) ? in_end_x : in_start_x;
  assign lo_y = (in_start_y < in_end_y) ? in_start_y : in_end_y;
  assign hi_y = (in_start_y < in_end_y) ? in_end_y : in_start_y;

  always_comb begin
    q_cmd          = '0;
    q_cmd.white    = in_ink_white;
    q_cmd.addr     = in_byte_address;
    q_cmd.value    = in_byte_value;
    q_cmd.in_store = {16'd0, in_byte_address} < 32'(STORE_BYTES);
    q_cmd.x0       = in_start_x;
    q_cmd.y0       = in_start_y;
    q_cmd.x1       = in_end_x;
    q_cmd.y1       = in_end_y;
    keep           = 1'b0;
    unique case (in_action)
      clr_pkg::ACT_DRAW: begin
        q_cmd.op = clr_pkg::OP_LINE;
        if (in_start_y == in_end_y) begin
          // Horizontal lines are ordered and clipped here, so the walker only
          // ever sees on-display pixels for them.
          keep = (in_start_y >= 16'sd0) && (in_start_y <= ROW_LAST) &&
                 (hi_x >= 16'sd0) && (lo_x <= COL_LAST);
          q_cmd.x0 = (lo_x < 16'sd0) ? 16'sd0 : lo_x;
          q_cmd.x1 = (hi_x > COL_LAST) ? COL_LAST : hi_x;
        end else if (in_start_x == in_end_x) begin
          keep = (in_start_x >= 16'sd0) && (in_start_x <= COL_LAST) &&
                 (hi_y >= 16'sd0) && (lo_y <= ROW_LAST);
          q_cmd.y0 = (lo_y < 16'sd0) ? 16'sd0 : lo_y;
          q_cmd.y1 = (hi_y > ROW_LAST) ? ROW_LAST : hi_y;
        end else begin
          keep = 1'b1;
        end
      end
      clr_pkg::ACT_WRITE: begin
        q_cmd.op = clr_pkg::OP_WRITE;
        keep     = 1'b1;
      end
      clr_pkg::ACT_READ: begin
        q_cmd.op = clr_pkg::OP_READ;
        keep     = 1'b1;
      end
      default: begin
        q_cmd.op = clr_pkg::OP_LINE;
        keep     = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/clr_queue.sv =====
module clr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  clr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output clr_pkg::cmd_t head_cmd
);

  clr_pkg::cmd_t slots_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_cmd   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== src/clr_back.sv =====
module clr_back #(
  parameter int PIXEL_COLUMNS = 800,
  parameter int PIXEL_ROWS    = 480
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  clr_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_read_value
);

  localparam int ROW_BYTES   = (PIXEL_COLUMNS + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * PIXEL_ROWS;
  localparam int IDX_W       = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int ERR_W       = clr_pkg::ERR_W;
  localparam logic signed [15:0] COL_LAST = 16'(PIXEL_COLUMNS - 1);
  localparam logic signed [15:0] ROW_LAST = 16'(PIXEL_ROWS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  logic [1:0] state_r, state_nxt;

  // Line walker registers.
  logic signed [15:0]      x_r, x_nxt, y_r, y_nxt, xe_r, xe_nxt, ye_r, ye_nxt;
  logic signed [ERR_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt, err_r, err_nxt;
  logic                    sx_neg_r, sx_neg_nxt, sy_neg_r, sy_neg_nxt;
  logic                    white_r, white_nxt;

  // Address stage.
  logic             p1_valid_r, p1_valid_nxt;
  logic [1:0]       p1_op_r, p1_op_nxt;
  logic [IDX_W-1:0] p1_idx_r, p1_idx_nxt;
  logic [2:0]       p1_bit_r, p1_bit_nxt;
  logic             p1_white_r, p1_white_nxt;
  logic [7:0]       p1_value_r, p1_value_nxt;
  logic             p1_in_store_r, p1_in_store_nxt;

  // Modify and write stage.
  logic             p2_valid_r;
  logic [1:0]       p2_op_r;
  logic [IDX_W-1:0] p2_idx_r;
  logic [2:0]       p2_bit_r;
  logic             p2_white_r;
  logic [7:0]       p2_value_r;
  logic             p2_in_store_r;

  logic [7:0]       frame_r [STORE_BYTES];
  logic [7:0]       rdata_r;
  logic             wr_valid_r;
  logic [IDX_W-1:0] wr_idx_r;
  logic [7:0]       wr_data_r;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_data_r;

  logic                    read_busy, rd_en, wen, on_disp, at_end, x_step, y_step;
  logic signed [16:0]      dxs, dys, adx, ady;
  logic signed [ERR_W:0]   e2;
  logic [IDX_W-1:0]        pix_idx;
  logic [7:0]              mask, old_byte, new_byte;

  assign out_valid      = out_valid_r;
  assign out_read_value = out_data_r;

  // Only one read is in flight at a time, and only while the output is empty,
  // so the pipeline never has to stall behind the result.
  assign read_busy = out_valid_r || (p1_valid_r && p1_op_r == clr_pkg::OP_READ) ||
                     (p2_valid_r && p2_op_r == clr_pkg::OP_READ);
  assign q_pop = (state_r == ST_IDLE) && q_valid &&
                 !(q_cmd.op == clr_pkg::OP_READ && read_busy);

  assign dxs = {q_cmd.x1[15], q_cmd.x1} - {q_cmd.x0[15], q_cmd.x0};
  assign dys = {q_cmd.y1[15], q_cmd.y1} - {q_cmd.y0[15], q_cmd.y0};
  assign adx = dxs[16] ? -dxs : dxs;
  assign ady = dys[16] ? -dys : dys;

  assign on_disp = (x_r >= 16'sd0) && (x_r <= COL_LAST) &&
                   (y_r >= 16'sd0) && (y_r <= ROW_LAST);
  assign pix_idx = IDX_W'($unsigned(y_r)) * IDX_W'(ROW_BYTES) + IDX_W'(x_r[15:3]);
  assign at_end  = (x_r == xe_r) && (y_r == ye_r);
  assign e2      = {err_r, 1'b0};
  assign x_step  = e2 >= (ERR_W+1)'(dy_r);
  assign y_step  = e2 <= (ERR_W+1)'(dx_r);

  always_comb begin
    state_nxt       = state_r;
    x_nxt           = x_r;
    y_nxt           = y_r;
    xe_nxt          = xe_r;
    ye_nxt          = ye_r;
    dx_nxt          = dx_r;
    dy_nxt          = dy_r;
    err_nxt         = err_r;
    sx_neg_nxt      = sx_neg_r;
    sy_neg_nxt      = sy_neg_r;
    white_nxt       = white_r;
    p1_valid_nxt    = 1'b0;
    p1_op_nxt       = q_cmd.op;
    p1_idx_nxt      = IDX_W'(q_cmd.addr);
    p1_bit_nxt      = 3'd0;
    p1_white_nxt    = white_r;
    p1_value_nxt    = q_cmd.value;
    p1_in_store_nxt = q_cmd.in_store;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          unique case (q_cmd.op)
            clr_pkg::OP_LINE: begin
              x_nxt      = q_cmd.x0;
              y_nxt      = q_cmd.y0;
              xe_nxt     = q_cmd.x1;
              ye_nxt     = q_cmd.y1;
              dx_nxt     = ERR_W'(adx);
              dy_nxt     = ERR_W'(-ady);
              sx_neg_nxt = dxs[16];
              sy_neg_nxt = dys[16];
              white_nxt  = q_cmd.white;
              state_nxt  = ST_SETUP;
            end
            default: begin
              p1_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SETUP: begin
        err_nxt   = dx_r + dy_r;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        p1_valid_nxt    = on_disp;
        p1_op_nxt       = clr_pkg::OP_LINE;
        p1_idx_nxt      = pix_idx;
        p1_bit_nxt      = x_r[2:0];
        p1_in_store_nxt = 1'b1;
        if (at_end) begin
          state_nxt = ST_IDLE;
        end else begin
          err_nxt = err_r + (x_step ? dy_r : '0) + (y_step ? dx_r : '0);
          if (x_step) begin
            x_nxt = sx_neg_r ? x_r - 16'sd1 : x_r + 16'sd1;
          end
          if (y_step) begin
            y_nxt = sy_neg_r ? y_r - 16'sd1 : y_r + 16'sd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // A byte written in the previous cycle was read stale by the item now in
  // the write stage, so it is taken from the last write instead.
  always_comb begin
    mask     = clr_pkg::PIX_MSB >> p2_bit_r;
    old_byte = (wr_valid_r && wr_idx_r == p2_idx_r) ? wr_data_r : rdata_r;
    if (p2_op_r == clr_pkg::OP_WRITE) begin
      new_byte = p2_value_r;
    end else if (p2_white_r) begin
      new_byte = old_byte | mask;
    end else begin
      new_byte = old_byte & ~mask;
    end
    rd_en = p1_valid_r && p1_in_store_r && (p1_op_r != clr_pkg::OP_WRITE);
    wen   = p2_valid_r && p2_in_store_r && (p2_op_r != clr_pkg::OP_READ);
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (p2_valid_r && p2_op_r == clr_pkg::OP_READ) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      wr_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p1_valid_r  <= p1_valid_nxt;
      p2_valid_r  <= p1_valid_r;
      wr_valid_r  <= wen;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r           <= x_nxt;
    y_r           <= y_nxt;
    xe_r          <= xe_nxt;
    ye_r          <= ye_nxt;
    dx_r          <= dx_nxt;
    dy_r          <= dy_nxt;
    err_r         <= err_nxt;
    sx_neg_r      <= sx_neg_nxt;
    sy_neg_r      <= sy_neg_nxt;
    white_r       <= white_nxt;
    p1_op_r       <= p1_op_nxt;
    p1_idx_r      <= p1_idx_nxt;
    p1_bit_r      <= p1_bit_nxt;
    p1_white_r    <= p1_white_nxt;
    p1_value_r    <= p1_value_nxt;
    p1_in_store_r <= p1_in_store_nxt;
    p2_op_r       <= p1_op_r;
    p2_idx_r      <= p1_idx_r;
    p2_bit_r      <= p1_bit_r;
    p2_white_r    <= p1_white_r;
    p2_value_r    <= p1_value_r;
    p2_in_store_r <= p1_in_store_r;
    wr_idx_r      <= p2_idx_r;
    wr_data_r     <= new_byte;
    if (p2_valid_r && p2_op_r == clr_pkg::OP_READ) begin
      out_data_r <= p2_in_store_r ? old_byte : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= frame_r[p1_idx_r];
    end
    if (wen) begin
      frame_r[p2_idx_r] <= new_byte;
    end
  end

endmodule

// ===== bench/tb_clipped_line_raster_1bpp.sv =====
`timescale 1ns / 1ps

module tb_clipped_line_raster_1bpp;

  localparam int PIXEL_COLUMNS = 800;
  localparam int PIXEL_ROWS    = 480;
  localparam int ROW_BYTES     = (PIXEL_COLUMNS + 7) / 8;
  localparam int STORE_BYTES   = ROW_BYTES * PIXEL_ROWS;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int ITEM_GOAL    = 750;
  localparam int FAR_LINE_CAP = 4;
  localparam int STALL_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 200;
  localparam int NO_PIN       = -1;

  typedef struct {
    logic [1:0]         action;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic               ink;
    logic [15:0]        addr;
    logic [7:0]         value;
  } raster_cmd_t;

  typedef struct {
    raster_cmd_t cmd;
    bit          pinned;
    logic [7:0]  pinned_byte;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_action = '0;
  logic signed [15:0] in_start_x = '0;
  logic signed [15:0] in_start_y = '0;
  logic signed [15:0] in_end_x = '0;
  logic signed [15:0] in_end_y = '0;
  logic               in_ink_white = 1'b0;
  logic [15:0]        in_byte_address = '0;
  logic [7:0]         in_byte_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_read_value;

  // Shadow of the frame memory plus a record of which bytes the host has loaded.
  logic [7:0] frame_model [STORE_BYTES];
  bit         byte_loaded [STORE_BYTES];
  int         loaded_addrs [$];
  logic [7:0] pending_reads [$];
  stim_row_t  directed_rows [$];
  logic [7:0] oldest_read;

  int items_sent   = 0;
  int far_lines    = 0;
  int fail_count   = 0;
  int stall_cycles = 0;
  bit no_gaps      = 1'b0;

  clipped_line_raster_1bpp #(
    .PIXEL_COLUMNS(PIXEL_COLUMNS),
    .PIXEL_ROWS(PIXEL_ROWS)
  ) dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void plot(int x, int y, bit white);
    int idx;
    logic [2:0] sub;
    if (x < 0 || x >= PIXEL_COLUMNS || y < 0 || y >= PIXEL_ROWS) return;
    idx = y * ROW_BYTES + x / 8;
    sub = x[2:0];
    if (white) frame_model[idx] = frame_model[idx] | (clr_pkg::PIX_MSB >> sub);
    else frame_model[idx] = frame_model[idx] & ~(clr_pkg::PIX_MSB >> sub);
  endfunction

  function automatic void trace_line(int x0, int y0, int x1, int y1, bit white);
    int t, dx, dy, sx, sy, err, e2;
    bit done;
    if (y0 == y1) begin
      if (y0 < 0 || y0 >= PIXEL_ROWS) return;
      if (x0 > x1) begin
        t = x0;
        x0 = x1;
        x1 = t;
      end
      if (x1 < 0 || x0 >= PIXEL_COLUMNS) return;
      if (x0 < 0) x0 = 0;
      if (x1 >= PIXEL_COLUMNS) x1 = PIXEL_COLUMNS - 1;
      for (t = x0; t <= x1; t++) plot(t, y0, white);
      return;
    end
    if (x0 == x1) begin
      if (x0 < 0 || x0 >= PIXEL_COLUMNS) return;
      if (y0 > y1) begin
        t = y0;
        y0 = y1;
        y1 = t;
      end
      if (y1 < 0 || y0 >= PIXEL_ROWS) return;
      if (y0 < 0) y0 = 0;
      if (y1 >= PIXEL_ROWS) y1 = PIXEL_ROWS - 1;
      for (t = y0; t <= y1; t++) plot(x0, t, white);
      return;
    end
    // Bresenham with dy kept negative; 32-bit terms cannot overflow for 16-bit ends.
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y0 - y1 : y1 - y0;
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = dx + dy;
    done = 1'b0;
    while (!done) begin
      plot(x0, y0, white);
      if (x0 == x1 && y0 == y1) done = 1'b1;
      else begin
        e2 = 2 * err;
        if (e2 >= dy) begin
          err += dy;
          x0 += sx;
        end
        if (e2 <= dx) begin
          err += dx;
          y0 += sy;
        end
      end
    end
  endfunction

  function automatic void apply_to_frame(input raster_cmd_t c, output bit gives_byte,
                                         output logic [7:0] byte_out);
    gives_byte = 1'b0;
    byte_out = 8'h00;
    case (c.action)
      clr_pkg::ACT_DRAW: trace_line(int'(c.sx), int'(c.sy), int'(c.ex), int'(c.ey), c.ink);
      clr_pkg::ACT_WRITE: begin
        if (c.addr < STORE_BYTES) begin
          frame_model[c.addr] = c.value;
          if (!byte_loaded[c.addr]) begin
            byte_loaded[c.addr] = 1'b1;
            loaded_addrs.push_back(int'(c.addr));
          end
        end
      end
      clr_pkg::ACT_READ: begin
        gives_byte = 1'b1;
        if (c.addr < STORE_BYTES) byte_out = frame_model[c.addr];
      end
      default: ;
    endcase
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic raster_cmd_t junk_cmd(logic [1:0] action);
    raster_cmd_t c;
    c.action = action;
    c.sx = 16'($urandom);
    c.sy = 16'($urandom);
    c.ex = 16'($urandom);
    c.ey = 16'($urandom);
    c.ink = 1'($urandom_range(1));
    c.addr = 16'($urandom);
    c.value = 8'($urandom);
    return c;
  endfunction

  function automatic stim_row_t stim_row(logic [1:0] action, int sx, int sy, int ex, int ey,
                                         bit ink, int addr, int value, int pin);
    stim_row_t r;
    r.cmd.action = action;
    r.cmd.sx = 16'(sx);
    r.cmd.sy = 16'(sy);
    r.cmd.ex = 16'(ex);
    r.cmd.ey = 16'(ey);
    r.cmd.ink = ink;
    r.cmd.addr = 16'(addr);
    r.cmd.value = 8'(value);
    r.pinned = (pin != NO_PIN);
    r.pinned_byte = 8'(pin);
    return r;
  endfunction

  // Endpoints fall around a loaded patch; a rare line gets one far end for the clipper.
  function automatic raster_cmd_t line_near(int xlo, int xhi, int ylo, int yhi);
    raster_cmd_t c;
    c = junk_cmd(clr_pkg::ACT_DRAW);
    c.sx = 16'(rand_between(xlo, xhi));
    c.ex = 16'(rand_between(xlo, xhi));
    c.sy = 16'(rand_between(ylo, yhi));
    c.ey = 16'(rand_between(ylo, yhi));
    case ($urandom_range(5))
      0: c.ey = c.sy;
      1: c.ex = c.sx;
      2: begin
        c.ex = c.sx;
        c.ey = c.sy;
      end
      default: ;
    endcase
    if (far_lines < FAR_LINE_CAP && $urandom_range(49) == 0) begin
      far_lines++;
      if (c.sy == c.ey) c.ex = 16'($urandom);
      else c.ey = 16'($urandom);
    end
    return c;
  endfunction

  task automatic push_item(input raster_cmd_t c, input bit pinned, input logic [7:0] pinned_byte);
    bit gives_byte;
    logic [7:0] predicted;
    if (!no_gaps) begin
      while ($urandom_range(99) < 32) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_action       <= c.action;
    in_start_x      <= c.sx;
    in_start_y      <= c.sy;
    in_end_x        <= c.ex;
    in_end_y        <= c.ey;
    in_ink_white    <= c.ink;
    in_byte_address <= c.addr;
    in_byte_value   <= c.value;
    do @(posedge clk); while (!in_ready);
    apply_to_frame(c, gives_byte, predicted);
    if (gives_byte) pending_reads.push_back(pinned ? pinned_byte : predicted);
    if (c.action != ACT_UNUSED) items_sent++;
  endtask

  // Load a small patch of bytes, draw across it, then read the whole patch back and at times one loaded byte.
  task automatic area_sequence();
    raster_cmd_t c;
    int bc, br, w, h;
    case ($urandom_range(5))
      0: bc = 0;
      1: bc = ROW_BYTES - 1;
      default: bc = $urandom_range(ROW_BYTES - 1);
    endcase
    case ($urandom_range(5))
      0: br = 0;
      1: br = PIXEL_ROWS - 1;
      default: br = $urandom_range(PIXEL_ROWS - 1);
    endcase
    w = $urandom_range(3, 1);
    if (bc + w > ROW_BYTES) w = ROW_BYTES - bc;
    h = $urandom_range(4, 1);
    if (br + h > PIXEL_ROWS) h = PIXEL_ROWS - br;
    for (int r = 0; r < h; r++) begin
      for (int b = 0; b < w; b++) begin
        c = junk_cmd(clr_pkg::ACT_WRITE);
        c.addr = 16'((br + r) * ROW_BYTES + bc + b);
        c.value = pick_byte();
        push_item(c, 1'b0, 8'h00);
      end
    end
    repeat ($urandom_range(4, 1)) begin
      push_item(line_near(bc * 8 - 12, (bc + w) * 8 + 11, br - 6, br + h + 5), 1'b0, 8'h00);
    end
    for (int r = 0; r < h; r++) begin
      for (int b = 0; b < w; b++) begin
        c = junk_cmd(clr_pkg::ACT_READ);
        c.addr = 16'((br + r) * ROW_BYTES + bc + b);
        push_item(c, 1'b0, 8'h00);
      end
    end
    if ($urandom_range(3) == 0) begin
      c = junk_cmd(clr_pkg::ACT_READ);
      c.addr = 16'(loaded_addrs[$urandom_range(loaded_addrs.size() - 1)]);
      push_item(c, 1'b0, 8'h00);
    end
  endtask

  task automatic stray_item();
    raster_cmd_t c;
    case ($urandom_range(5))
      0: c = junk_cmd(ACT_UNUSED);
      1: begin
        c = junk_cmd(clr_pkg::ACT_WRITE);
        c.addr = 16'($urandom_range(65535, STORE_BYTES));
      end
      2: begin
        c = junk_cmd(clr_pkg::ACT_READ);
        c.addr = 16'($urandom_range(65535, STORE_BYTES));
      end
      3: begin
        c = junk_cmd(clr_pkg::ACT_WRITE);
        c.addr = 16'($urandom_range(STORE_BYTES - 1));
        c.value = pick_byte();
      end
      4: begin
        c = junk_cmd(clr_pkg::ACT_READ);
        c.addr = 16'(loaded_addrs[$urandom_range(loaded_addrs.size() - 1)]);
      end
      default: begin
        c = junk_cmd(clr_pkg::ACT_DRAW);
        c.sx = 16'(rand_between(-24, PIXEL_COLUMNS + 23));
        c.sy = 16'(rand_between(-24, PIXEL_ROWS + 23));
        c.ex = 16'(c.sx + rand_between(-40, 40));
        c.ey = 16'(c.sy + rand_between(-40, 40));
      end
    endcase
    push_item(c, 1'b0, 8'h00);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_reads.size() == 0) begin
          $error("read_value with no read pending: expected none, actual %02h", out_read_value);
          fail_count++;
        end else begin
          oldest_read = pending_reads.pop_front();
          if (out_read_value !== oldest_read) begin
            $error("read_value mismatch: expected %02h, actual %02h", oldest_read, out_read_value);
            fail_count++;
          end
        end
      end
      out_ready <= no_gaps || ($urandom_range(99) >= 32);
    end
  end

  // A full-range draw can hold off the input; anything far past the longest draw is taken as a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL clipped_line_raster_1bpp");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    directed_rows.push_back(stim_row(clr_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 0, 8'h00, NO_PIN));
    directed_rows.push_back(stim_row(clr_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 1, 8'h5A, NO_PIN));
    directed_rows.push_back(stim_row(clr_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 99, 8'h00, NO_PIN));
    directed_rows.push_back(stim_row(clr_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 47900, 8'hFF, NO_PIN));
    directed_rows.push_back(stim_row(clr_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 47999, 8'hFF, NO_PIN));
    directed_rows.push_back(stim_row(clr_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 48000, 8'hA5, NO_PIN));
    directed_rows.push_back(stim_row(clr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 8'h00));
    directed_rows.push_back(stim_row(clr_pkg::ACT_READ, 0, 0, 0, 0, 0, 47999, 0, 8'hFF));
    directed_rows.push_back(stim_row(clr_pkg::ACT_READ, 0, 0, 0, 0, 0, 48000, 0, 8'h00));
    directed_rows.push_back(stim_row(clr_pkg::ACT_READ, 0, 0, 0, 0, 0, 65535, 0, 8'h00));
    directed_rows.push_back(stim_row(ACT_UNUSED, -1, 12345, -32768, 7, 1, 47999, 8'h3C, NO_PIN));
    directed_rows.push_back(stim_row(clr_pkg::ACT_DRAW, 0, 0, 0, 0, 1, 0, 0, NO_PIN));
    directed_rows.push_back(stim_row(clr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 8'h80));
    directed_rows.push_back(stim_row(clr_pkg::ACT_DRAW, 32767, 0, -32768, 0, 1, 0, 0, NO_PIN));
    directed_rows.push_back(stim_row(clr_pkg::ACT_READ, 0, 0, 0, 0, 0, 1, 0, 8'hFF));
    directed_rows.push_back(stim_row(clr_pkg::ACT_READ, 0, 0, 0, 0, 0, 99, 0, 8'hFF));
    directed_rows.push_back(stim_row(clr_pkg::ACT_DRAW, 799, 32767, 799, -32768, 0, 0, 0,
                                     NO_PIN));
    directed_rows.push_back(stim_row(clr_pkg::ACT_READ, 0, 0, 0, 0, 0, 47999, 0, 8'hFE));
    directed_rows.push_back(stim_row(clr_pkg::ACT_DRAW, -32768, -32768, 32767, 32767, 0, 0, 0,
                                     NO_PIN));
    directed_rows.push_back(stim_row(clr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, NO_PIN));
    directed_rows.push_back(stim_row(clr_pkg::ACT_DRAW, -100, -50, -10, -5, 1, 0, 0, NO_PIN));
    directed_rows.push_back(stim_row(clr_pkg::ACT_DRAW, 5, -3, 2, 10, 1, 0, 0, NO_PIN));
    directed_rows.push_back(stim_row(clr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, NO_PIN));
    directed_rows.push_back(stim_row(clr_pkg::ACT_DRAW, 0, 479, 7, 479, 0, 0, 0, NO_PIN));
    directed_rows.push_back(stim_row(clr_pkg::ACT_READ, 0, 0, 0, 0, 0, 47900, 0, 8'h00));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      push_item(directed_rows[i].cmd, directed_rows[i].pinned, directed_rows[i].pinned_byte);
    end

    while (items_sent < ITEM_GOAL) begin
      no_gaps <= (items_sent >= 300 && items_sent < 420);
      if ($urandom_range(99) < 80) area_sequence();
      else stray_item();
    end
    in_valid <= 1'b0;

    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS clipped_line_raster_1bpp");
    end else begin
      $display("FAIL clipped_line_raster_1bpp");
    end
    $finish;
  end

endmodule
